### design/rht_pkg.sv
`default_nettype none

package rht_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int COORD_W   = 32;

    localparam int NUM_CELLS = (MAX_ITEMS >= 8) ? 8 : ((MAX_ITEMS >= 4) ? 4 : 2);
    localparam int CELL_BITS = $clog2(NUM_CELLS);
    localparam int ROWS      = (MAX_ITEMS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENTRY_W   = ROW_BITS + CELL_BITS;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int RECT_W    = 4 * COORD_W;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } rect_t;

    typedef struct packed {
        logic                      en;
        logic [CELL_BITS-1:0]      lane;
        logic [ROW_BITS-1:0]       row;
        rect_t                     rect;
    } wr_t;

    // query token traveling down the chain, one row of the table per token
    typedef struct packed {
        logic                      valid;
        logic [ROW_BITS-1:0]       row;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      found;
        logic [ENTRY_W-1:0]        idx;
    } token_t;

endpackage

`default_nettype wire

### design/rht_ram.sv
`default_nettype none

module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/rht_cell.sv
`default_nettype none

module rht_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rht_pkg::CELL_BITS-1:0] cell_id,
    input  wire logic [rht_pkg::CNT_W-1:0]     count,
    input  wire logic                          kill,
    input  wire rht_pkg::wr_t                  wr,
    input  wire rht_pkg::token_t               tok_in,
    output rht_pkg::token_t                    tok_out
);
    import rht_pkg::*;

    logic                tok_valid_reg;
    logic                tok_valid_next;
    token_t              tok_reg;
    logic [RECT_W-1:0]   ram_q;
    rect_t               rect;
    logic [ENTRY_W-1:0]  entry;
    logic                in_range;
    logic                hit;

    rht_ram #(
        .WIDTH (RECT_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en && (wr.lane == cell_id)),
        .waddr (wr.row),
        .wdata (wr.rect),
        .raddr (tok_in.row),
        .rdata (ram_q)
    );

    assign tok_valid_next = tok_in.valid && !kill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_in;
    end

    always_comb
    begin
        rect     = rect_t'(ram_q);
        entry    = {tok_reg.row, cell_id};
        in_range = {1'b0, entry} < (ENTRY_W + 1)'(count);
        hit      = in_range &&
                   (tok_reg.px >= rect.min_x) && (tok_reg.px <= rect.max_x) &&
                   (tok_reg.py >= rect.min_y) && (tok_reg.py <= rect.max_y);

        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
        // higher cells hold higher indexes of the same row
        if (hit)
        begin
            tok_out.found = 1'b1;
            tok_out.idx   = entry;
        end
    end

endmodule

`default_nettype wire

### design/rectangle_hit_test_core.sv
`default_nettype none

// Rectangle hit test over a table of up to MAX_ITEMS axis-aligned rectangles.
// A transaction is taken at a rising edge with start high and busy low; func
// selects clear, insert or query. Every transaction gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it.
// Clear, insert and unknown codes answer in the cycle after acceptance and busy
// stays low, so they can be issued every cycle.
// Entry k lives in cell k mod NUM_CELLS at row k / NUM_CELLS. A query walks
// the rows from the top one down, one row entering the chain of NUM_CELLS
// cells per cycle; each cell reads its row, tests the point, and hands the
// best hit so far to its neighbor. The first row leaving the chain with a hit
// ends the query and the rows still in flight are dropped.
// busy is high while a query runs. Each row passes the issue registers and
// then one register per cell, and the result is registered from the row that
// ends the query. A query on an empty table misses without a scan, busy low.
// Reset empties the table (entry count zero); the rectangle store itself
// is not cleared.
module rectangle_hit_test_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         func,
    input  wire logic signed [rht_pkg::COORD_W-1:0] corner_a_x,
    input  wire logic signed [rht_pkg::COORD_W-1:0] corner_a_y,
    input  wire logic signed [rht_pkg::COORD_W-1:0] corner_b_x,
    input  wire logic signed [rht_pkg::COORD_W-1:0] corner_b_y,
    input  wire logic signed [rht_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [rht_pkg::COORD_W-1:0] point_y,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic [rht_pkg::IDX_W-1:0]               hit_index,
    output logic [rht_pkg::CNT_W-1:0]               entry_total
);
    import rht_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                       state_reg,     state_next;
    logic [CNT_W-1:0]           count_reg,     count_next;
    logic                       issuing_reg,   issuing_next;
    logic [ROW_BITS-1:0]        issue_row_reg, issue_row_next;
    logic signed [COORD_W-1:0]  px_reg,        px_next;
    logic signed [COORD_W-1:0]  py_reg,        py_next;
    logic                       done_reg,      done_next;
    logic [1:0]                 status_reg,    status_next;
    logic [IDX_W-1:0]           hit_reg,       hit_next;
    logic [CNT_W-1:0]           total_reg,     total_next;

    logic                       accept;
    logic                       full;
    logic                       finish;
    logic [CNT_W-1:0]           cnt_last;
    wr_t                        wr;
    token_t                     chain [NUM_CELLS + 1];

    assign accept   = start && !busy;
    assign full     = count_reg >= CNT_W'(MAX_ITEMS);
    assign cnt_last = count_reg - CNT_W'(1);
    assign finish   = (state_reg == S_SCAN) && chain[NUM_CELLS].valid &&
                      (chain[NUM_CELLS].found || (chain[NUM_CELLS].row == '0));

    always_comb
    begin
        wr.en         = accept && (func == FUNC_INSERT) && !full;
        wr.lane       = count_reg[CELL_BITS-1:0];
        wr.row        = ROW_BITS'(count_reg >> CELL_BITS);
        wr.rect.min_x = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
        wr.rect.max_x = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
        wr.rect.min_y = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
        wr.rect.max_y = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
    end

    always_comb
    begin
        chain[0].valid = issuing_reg;
        chain[0].row   = issue_row_reg;
        chain[0].px    = px_reg;
        chain[0].py    = py_reg;
        chain[0].found = 1'b0;
        chain[0].idx   = '0;
    end

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rht_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (CELL_BITS'(i)),
            .count   (count_reg),
            .kill    (finish),
            .wr      (wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i + 1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issuing_next   = issuing_reg;
        issue_row_next = issue_row_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        hit_next       = hit_reg;
        total_next     = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    hit_next    = '0;
                    total_next  = count_reg;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        FUNC_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                hit_next   = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                                total_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISS;
                            end
                            else
                            begin
                                done_next      = 1'b0;
                                state_next     = S_SCAN;
                                issuing_next   = 1'b1;
                                issue_row_next = ROW_BITS'(cnt_last >> CELL_BITS);
                                px_next        = point_x;
                                py_next        = point_y;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issuing_reg)
                begin
                    if (issue_row_reg == '0)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        issue_row_next = issue_row_reg - ROW_BITS'(1);
                    end
                end
                if (finish)
                begin
                    state_next   = S_IDLE;
                    issuing_next = 1'b0;
                    done_next    = 1'b1;
                    total_next   = count_reg;
                    if (chain[NUM_CELLS].found)
                    begin
                        status_next = ST_OK;
                        hit_next    = IDX_W'(chain[NUM_CELLS].idx);
                    end
                    else
                    begin
                        status_next = ST_MISS;
                        hit_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next   = S_IDLE;
                issuing_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            issuing_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issuing_reg <= issuing_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_row_reg <= issue_row_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        total_reg     <= total_next;
    end

    assign busy        = (state_reg == S_SCAN);
    assign done        = done_reg;
    assign status      = status_reg;
    assign hit_index   = hit_reg;
    assign entry_total = total_reg;

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_INSERT) && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance entry count");

    a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (count_reg == $past(count_reg)))
        else $error("entry count changed during a query");

    a_chain_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain[NUM_CELLS].valid |-> busy)
        else $error("stale token left the chain");

    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_OK) && (entry_total != '0)) |->
            (CNT_W'(hit_index) < entry_total))
        else $error("reported index beyond stored entries");

endmodule

`default_nettype wire

### bench/rectangle_hit_test_core_test.sv
`timescale 1ns / 100ps

module rectangle_hit_test_core_test;

    import rht_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_AFTER   = 1450;
    localparam int FILL_PHASE   = 4;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = NUM_CELLS + 2 + ROWS + 16;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } txn_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] total;
    } answer_t;

    class hit_test_scoreboard;
        logic signed [COORD_W-1:0] lo_x [MAX_ITEMS];
        logic signed [COORD_W-1:0] lo_y [MAX_ITEMS];
        logic signed [COORD_W-1:0] hi_x [MAX_ITEMS];
        logic signed [COORD_W-1:0] hi_y [MAX_ITEMS];
        int                        stored;
        answer_t                   answer_q[$];
        int                        errors;

        function new();
            stored = 0;
            errors = 0;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        function void note_transaction(txn_t t);
            answer_t                   a;
            int                        k;
            logic signed [COORD_W-1:0] ax, ay, bx, by, px, py;
            ax = t.ax;
            ay = t.ay;
            bx = t.bx;
            by = t.by;
            px = t.px;
            py = t.py;
            a.status = ST_OK;
            a.index  = '0;
            case (t.func)
                FUNC_CLEAR:
                    stored = 0;
                FUNC_INSERT:
                    if (stored >= MAX_ITEMS)
                        a.status = ST_FULL;
                    else
                    begin
                        lo_x[stored] = (ax < bx) ? ax : bx;
                        hi_x[stored] = (ax < bx) ? bx : ax;
                        lo_y[stored] = (ay < by) ? ay : by;
                        hi_y[stored] = (ay < by) ? by : ay;
                        a.index = IDX_W'(stored);
                        stored++;
                    end
                FUNC_QUERY:
                begin
                    a.status = ST_MISS;
                    for (k = stored - 1; k >= 0; k--)
                    begin
                        if (px >= lo_x[k] && px <= hi_x[k] && py >= lo_y[k] && py <= hi_y[k])
                        begin
                            a.status = ST_OK;
                            a.index  = IDX_W'(k);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            a.total = CNT_W'(stored);
            answer_q = {answer_q, a};
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 50)
                $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(logic [1:0] st, logic [IDX_W-1:0] idx, logic [CNT_W-1:0] tot);
            answer_t a;
            if (answer_q.size() == 0)
                report_mismatch($sformatf("result with nothing pending (status %0d)", st));
            else
            begin
                a = answer_q.pop_front();
                if (st !== a.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, a.status));
                if (idx !== a.index)
                    report_mismatch($sformatf("hit_index %0d, want %0d", idx, a.index));
                if (tot !== a.total)
                    report_mismatch($sformatf("entry_total %0d, want %0d", tot, a.total));
            end
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                func = FUNC_CLEAR;
    logic signed [COORD_W-1:0] corner_a_x = '0;
    logic signed [COORD_W-1:0] corner_a_y = '0;
    logic signed [COORD_W-1:0] corner_b_x = '0;
    logic signed [COORD_W-1:0] corner_b_y = '0;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic                      done;
    logic [1:0]                status;
    logic [IDX_W-1:0]          hit_index;
    logic [CNT_W-1:0]          entry_total;

    hit_test_scoreboard sb = new();
    int                 cycle_count = 0;
    int                 random_done = 0;

    rectangle_hit_test_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .corner_a_x  (corner_a_x),
        .corner_a_y  (corner_a_y),
        .corner_b_x  (corner_b_x),
        .corner_b_y  (corner_b_y),
        .point_x     (point_x),
        .point_y     (point_y),
        .done        (done),
        .status      (status),
        .hit_index   (hit_index),
        .entry_total (entry_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(status, hit_index, entry_total);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return COORD_MIN;
            2: return COORD_MAX;
            3: return int'($urandom_range(0, 200)) - 100;
            4: return COORD_MIN + $urandom_range(0, 15);
            5: return COORD_MAX - $urandom_range(0, 15);
            default: return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        endcase
    endfunction

    // point coordinate within [lo, hi], edges favored
    function automatic logic signed [COORD_W-1:0] coord_between(
        logic signed [COORD_W-1:0] lo, logic signed [COORD_W-1:0] hi);
        longint          span;
        longint unsigned r;
        longint          v;
        span = longint'(hi) - longint'(lo);
        r    = {$urandom, $urandom};
        v    = longint'(lo) + longint'(r % longint'(span + 1));
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return v[COORD_W-1:0];
        endcase
    endfunction

    function automatic txn_t noise_txn(logic [1:0] f);
        txn_t t;
        t.func = f;
        t.ax   = $urandom;
        t.ay   = $urandom;
        t.bx   = $urandom;
        t.by   = $urandom;
        t.px   = $urandom;
        t.py   = $urandom;
        return t;
    endfunction

    function automatic txn_t insert_txn();
        txn_t t;
        t    = noise_txn(FUNC_INSERT);
        t.ax = rand_coord();
        t.ay = rand_coord();
        t.bx = rand_coord();
        t.by = rand_coord();
        return t;
    endfunction

    function automatic txn_t query_txn(bit aim);
        txn_t t;
        int   k;
        t = noise_txn(FUNC_QUERY);
        if (aim && sb.stored > 0)
        begin
            k    = $urandom_range(0, sb.stored - 1);
            t.px = coord_between(sb.lo_x[k], sb.hi_x[k]);
            t.py = coord_between(sb.lo_y[k], sb.hi_y[k]);
        end
        else
        begin
            t.px = rand_coord();
            t.py = rand_coord();
        end
        return t;
    endfunction

    task send_txn(txn_t t);
        start      <= 1'b1;
        func       <= t.func;
        corner_a_x <= t.ax;
        corner_a_y <= t.ay;
        corner_b_x <= t.bx;
        corner_b_y <= t.by;
        point_x    <= t.px;
        point_y    <= t.py;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_transaction(t);
    endtask

    task idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 8))
            @(posedge clk);
    endtask

    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task step(txn_t t);
        send_txn(t);
        if (t.func != FUNC_UNUSED)
            random_done++;
        if (random_done < CALM_AFTER && $urandom_range(0, 5) == 0)
            idle_burst();
    endtask

    task put_insert(logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
                    logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
        txn_t t;
        t    = noise_txn(FUNC_INSERT);
        t.ax = ax;
        t.ay = ay;
        t.bx = bx;
        t.by = by;
        send_txn(t);
        if ($urandom_range(0, 2) == 0)
            idle_burst();
    endtask

    task put_query(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
        txn_t t;
        t    = noise_txn(FUNC_QUERY);
        t.px = px;
        t.py = py;
        send_txn(t);
        if ($urandom_range(0, 2) == 0)
            idle_burst();
    endtask

    task put_op(logic [1:0] f);
        send_txn(noise_txn(f));
    endtask

    task run_directed();
        put_query(0, 0);
        put_insert(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        put_query(COORD_MIN, COORD_MIN);
        put_query(COORD_MAX, COORD_MAX);
        put_insert(5, -7, 5, -7);
        put_query(5, -7);
        put_query(5, -6);
        put_op(FUNC_UNUSED);
        put_op(FUNC_CLEAR);
        put_query(0, 0);
        put_insert(100, -200, -100, 200);
        put_query(101, 0);
        put_query(-100, -200);
        put_query(100, 201);
        put_query(100, 200);
        put_insert(50, 50, 0, 0);
        put_query(25, 25);
        put_query(-50, 0);
        put_query(0, -1);
        put_insert(COORD_MIN, 0, COORD_MIN, COORD_MAX);
        put_query(COORD_MIN, COORD_MAX);
        put_query(COORD_MIN + 1, 5);
        put_op(FUNC_UNUSED);
        put_op(FUNC_CLEAR);
    endtask

    task run_phase(bit fill);
        int i;
        int n;
        int pick;
        if (fill)
        begin
            step(noise_txn(FUNC_CLEAR));
            for (i = 0; i < MAX_ITEMS + 3; i++)
                step(insert_txn());
            for (i = 0; i < 30; i++)
                step(query_txn($urandom_range(0, 9) < 7));
            step(noise_txn(FUNC_UNUSED));
        end
        else
        begin
            if ($urandom_range(0, 4) != 0)
                step(noise_txn(FUNC_CLEAR));
            n = $urandom_range(1, 40);
            for (i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    step(insert_txn());
                else if (pick < 88)
                    step(query_txn($urandom_range(0, 9) < 7));
                else if (pick < 95)
                    step(noise_txn(FUNC_UNUSED));
                else
                    step(noise_txn(FUNC_CLEAR));
            end
        end
    endtask

    initial
    begin
        int phase;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);
        run_directed();
        drain();
        phase = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            run_phase(phase == FILL_PHASE);
            phase++;
            if (random_done < CALM_AFTER && $urandom_range(0, 7) == 0)
                drain();
        end
        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/rht_pkg.sv
design/rht_ram.sv
design/rht_cell.sv
design/rectangle_hit_test_core.sv
bench/rectangle_hit_test_core_test.sv
